>>> rtl/core/mwe_pkg.sv
`default_nettype none

package mwe_pkg;

  localparam int WORD_W = 16;
  localparam int CNT_W  = 4;

  localparam logic [2:0] OP_TICK      = 3'd0;
  localparam logic [2:0] OP_READ      = 3'd1;
  localparam logic [2:0] OP_WRITE     = 3'd2;
  localparam logic [2:0] OP_ERASE_ALL = 3'd3;
  localparam logic [2:0] OP_ENABLE    = 3'd4;
  localparam logic [2:0] OP_DISABLE   = 3'd5;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_TIMEOUT = 2'd1;
  localparam logic [1:0] ST_REJECT  = 2'd2;

  localparam logic [15:0] POLL_LIMIT_RST = 16'd6000;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_RST_HI   = 4'd1,
    PH_RST_LO   = 4'd2,
    PH_CMD_LO   = 4'd3,
    PH_CMD_HI   = 4'd4,
    PH_RD_LO    = 4'd5,
    PH_RD_HI    = 4'd6,
    PH_WR_LO    = 4'd7,
    PH_WR_HI    = 4'd8,
    PH_WR_DESEL = 4'd9,
    PH_POLL     = 4'd10
  } phase_t;

  // sequencer state carried from item to item
  typedef struct packed {
    phase_t              phase;
    logic [CNT_W-1:0]    bit_cnt;
    logic [WORD_W-1:0]   shift_word;
    logic [2:0]          pend_cmd;
    logic [WORD_W-1:0]   poll_cnt;
    logic [WORD_W-1:0]   asm_word;
    logic [WORD_W-1:0]   write_hold;
  } mwe_state_t;

  // one result item
  typedef struct packed {
    logic                cs;
    logic                sclk;
    logic                dout;
    logic                busy;
    logic [WORD_W-1:0]   read_word;
    logic                done;
    logic [1:0]          status;
  } mwe_res_t;

endpackage

`default_nettype wire

>>> rtl/core/mwe_step.sv
`default_nettype none

module mwe_step
  import mwe_pkg::*;
#(
  parameter int COMMAND_BITS = 11,
  parameter int DATA_BITS    = 16,
  parameter int ADDRESS_BITS = 7
) (
  input  wire mwe_state_t        st,
  input  wire logic [2:0]        opcode,
  input  wire logic [6:0]        word_address,
  input  wire logic [WORD_W-1:0] write_data,
  input  wire logic              data_in_pin,
  input  wire logic [WORD_W-1:0] poll_limit,
  output mwe_state_t             st_nxt,
  output mwe_res_t               res
);

  localparam int FIELD_BITS = COMMAND_BITS - 3;

  localparam logic [WORD_W-1:0] FRM_START  = WORD_W'(1 << (COMMAND_BITS - 1));
  localparam logic [WORD_W-1:0] FRM_RD_OP  = WORD_W'(2 << FIELD_BITS);
  localparam logic [WORD_W-1:0] FRM_WR_OP  = WORD_W'(1 << FIELD_BITS);
  localparam logic [WORD_W-1:0] FLD_ENABLE = WORD_W'(3 << (FIELD_BITS - 2));
  localparam logic [WORD_W-1:0] FLD_ERASE  = WORD_W'(2 << (FIELD_BITS - 2));
  localparam logic [WORD_W-1:0] FIELD_MASK = WORD_W'((1 << FIELD_BITS) - 1);
  localparam logic [WORD_W-1:0] DATA_MASK  = WORD_W'((1 << DATA_BITS) - 1);
  localparam logic [6:0]        ADDR_MASK  = 7'((1 << ADDRESS_BITS) - 1);
  localparam logic [CNT_W-1:0]  CMD_LAST   = CNT_W'(COMMAND_BITS - 1);
  localparam logic [CNT_W-1:0]  DATA_LAST  = CNT_W'(DATA_BITS - 1);

  logic              is_cmd;
  logic              start;
  logic              rejected;
  mwe_state_t        eff;
  logic [WORD_W-1:0] addr_word;
  logic [WORD_W-1:0] frame;
  logic [WORD_W-1:0] field;
  logic [WORD_W-1:0] limit;
  logic [WORD_W-1:0] poll_inc;
  logic              poll_expire;
  logic [WORD_W-1:0] rd_shift;

  // command decode and frame build
  always_comb begin
    is_cmd    = opcode inside {[OP_READ:OP_DISABLE]};
    start     = (st.phase == PH_IDLE) && is_cmd;
    rejected  = (st.phase != PH_IDLE) && is_cmd;
    addr_word = {9'd0, word_address & ADDR_MASK};
    frame     = FRM_START;
    field     = '0;
    case (opcode)
      OP_READ: begin
        frame = FRM_START | FRM_RD_OP;
        field = addr_word;
      end
      OP_WRITE: begin
        frame = FRM_START | FRM_WR_OP;
        field = addr_word;
      end
      OP_ENABLE:    field = FLD_ENABLE;
      OP_ERASE_ALL: field = FLD_ERASE;
      default:      field = '0;
    endcase
    frame = frame | (field & FIELD_MASK);

    eff = st;
    if (start) begin
      eff.phase      = PH_RST_HI;
      eff.pend_cmd   = opcode;
      eff.shift_word = frame;
      eff.write_hold = write_data & DATA_MASK;
      eff.bit_cnt    = CMD_LAST;
      eff.poll_cnt   = '0;
    end
  end

  always_comb begin
    limit       = (poll_limit == '0) ? WORD_W'(1) : poll_limit;
    poll_inc    = eff.poll_cnt + WORD_W'(1);
    poll_expire = (poll_inc >= limit) || (poll_inc == '0);
    rd_shift    = {eff.shift_word[WORD_W-2:0], data_in_pin};
  end

  // next state
  always_comb begin
    st_nxt = eff;
    case (eff.phase)
      PH_IDLE:   st_nxt.phase = PH_IDLE;
      PH_RST_HI: st_nxt.phase = PH_RST_LO;
      PH_RST_LO: st_nxt.phase = PH_CMD_LO;
      PH_CMD_LO: st_nxt.phase = PH_CMD_HI;
      PH_CMD_HI: begin
        if (eff.bit_cnt != '0) begin
          st_nxt.bit_cnt = eff.bit_cnt - CNT_W'(1);
          st_nxt.phase   = PH_CMD_LO;
        end else if (eff.pend_cmd == OP_READ) begin
          st_nxt.bit_cnt    = DATA_LAST;
          st_nxt.shift_word = '0;
          st_nxt.phase      = PH_RD_LO;
        end else if (eff.pend_cmd == OP_WRITE) begin
          st_nxt.bit_cnt    = DATA_LAST;
          st_nxt.shift_word = eff.write_hold;
          st_nxt.phase      = PH_WR_LO;
        end else begin
          st_nxt.phase = PH_IDLE;
        end
      end
      PH_RD_LO: st_nxt.phase = PH_RD_HI;
      PH_RD_HI: begin
        st_nxt.shift_word = rd_shift;
        if (eff.bit_cnt != '0) begin
          st_nxt.bit_cnt = eff.bit_cnt - CNT_W'(1);
          st_nxt.phase   = PH_RD_LO;
        end else begin
          st_nxt.asm_word = rd_shift & DATA_MASK;
          st_nxt.phase    = PH_IDLE;
        end
      end
      PH_WR_LO: st_nxt.phase = PH_WR_HI;
      PH_WR_HI: begin
        if (eff.bit_cnt != '0) begin
          st_nxt.bit_cnt = eff.bit_cnt - CNT_W'(1);
          st_nxt.phase   = PH_WR_LO;
        end else begin
          st_nxt.phase = PH_WR_DESEL;
        end
      end
      PH_WR_DESEL: begin
        st_nxt.poll_cnt = '0;
        st_nxt.phase    = PH_POLL;
      end
      PH_POLL: begin
        if (data_in_pin) begin
          st_nxt.phase = PH_IDLE;
        end else begin
          st_nxt.poll_cnt = poll_inc;
          if (poll_expire) begin
            st_nxt.phase = PH_IDLE;
          end
        end
      end
      default: st_nxt.phase = PH_IDLE;
    endcase
  end

  // pin levels and completion
  always_comb begin
    res           = '0;
    res.read_word = st_nxt.asm_word;
    res.busy      = (st_nxt.phase != PH_IDLE);
    case (eff.phase)
      PH_RST_HI: res.sclk = 1'b1;
      PH_CMD_LO, PH_WR_LO: begin
        res.cs   = 1'b1;
        res.dout = eff.shift_word[eff.bit_cnt];
      end
      PH_CMD_HI: begin
        res.cs   = 1'b1;
        res.sclk = 1'b1;
        res.dout = eff.shift_word[eff.bit_cnt];
        res.done = (eff.bit_cnt == '0) && (eff.pend_cmd != OP_READ)
                   && (eff.pend_cmd != OP_WRITE);
      end
      PH_WR_HI: begin
        res.cs   = 1'b1;
        res.sclk = 1'b1;
        res.dout = eff.shift_word[eff.bit_cnt];
      end
      PH_RD_LO: res.cs = 1'b1;
      PH_RD_HI: begin
        res.cs   = 1'b1;
        res.sclk = 1'b1;
        res.done = (eff.bit_cnt == '0);
      end
      PH_POLL: begin
        res.cs   = 1'b1;
        res.done = data_in_pin || poll_expire;
        if (!data_in_pin && poll_expire) begin
          res.status = ST_TIMEOUT;
        end
      end
      default: res.cs = 1'b0;
    endcase
    if (rejected && !res.done) begin
      res.status = ST_REJECT;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/microwire_eeprom_master.sv
// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_ready    opcode, word_address, write_data, data_in_pin
// out      output     out_valid / out_ready  pin levels, busy_res, read_word, finished, status
// cfg      input      cfg_wr_en              poll_limit (cfg_wr_data)
//
// One item per clock while out_ready holds; path: input register, then result register.
// Each item is one pin-phase tick; the sequencer state steps once per item in one pass.
// rst_n is synchronous, active low: sequencer idle, poll_limit back to 6000.
// A stalled result holds in the output register while one more item waits in the
// input register; in_ready drops only when both are full and out_ready is low.
`default_nettype none

module microwire_eeprom_master
  import mwe_pkg::*;
#(
  parameter int COMMAND_BITS = 11,
  parameter int DATA_BITS    = 16,
  parameter int ADDRESS_BITS = 7
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // input items
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [2:0]        in_opcode,
  input  wire logic [6:0]        in_word_address,
  input  wire logic [WORD_W-1:0] in_write_data,
  input  wire logic              in_data_in_pin,
  // result items
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   out_chip_select,
  output logic                   out_serial_clock,
  output logic                   out_data_out_pin,
  output logic                   out_busy_res,
  output logic [WORD_W-1:0]      out_read_word,
  output logic                   out_finished,
  output logic [1:0]             out_status,
  // configuration
  input  wire logic              cfg_wr_en,
  input  wire logic [WORD_W-1:0] cfg_wr_data
);

  // input register
  logic              s1_vld_r;
  logic [2:0]        s1_op_r;
  logic [6:0]        s1_addr_r;
  logic [WORD_W-1:0] s1_wdata_r;
  logic              s1_din_r;

  // sequencer state, config and result register
  mwe_state_t        st_r;
  mwe_state_t        st_nxt;
  logic [WORD_W-1:0] poll_limit_r;
  logic              out_vld_r;
  mwe_res_t          res_r;
  mwe_res_t          res_nxt;

  logic              adv;

  // item in the input register moves on when the result slot frees up
  assign adv      = s1_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !s1_vld_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_ready) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_op_r    <= in_opcode;
      s1_addr_r  <= in_word_address;
      s1_wdata_r <= in_write_data;
      s1_din_r   <= in_data_in_pin;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poll_limit_r <= POLL_LIMIT_RST;
    end else if (cfg_wr_en) begin
      poll_limit_r <= cfg_wr_data;
    end
  end

  mwe_step #(
    .COMMAND_BITS (COMMAND_BITS),
    .DATA_BITS    (DATA_BITS),
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_step (
    .st           (st_r),
    .opcode       (s1_op_r),
    .word_address (s1_addr_r),
    .write_data   (s1_wdata_r),
    .data_in_pin  (s1_din_r),
    .poll_limit   (poll_limit_r),
    .st_nxt       (st_nxt),
    .res          (res_nxt)
  );

  // state steps exactly once per item, as it enters the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '{phase: PH_IDLE, default: '0};
    end else if (adv) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_chip_select  = res_r.cs;
  assign out_serial_clock = res_r.sclk;
  assign out_data_out_pin = res_r.dout;
  assign out_busy_res     = res_r.busy;
  assign out_read_word    = res_r.read_word;
  assign out_finished     = res_r.done;
  assign out_status       = res_r.status;

  // a completing item leaves the sequencer idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    adv && res_nxt.done |=> st_r.phase == PH_IDLE)
    else $error("sequencer not idle after completion");

  // busy flag in the result matches the state it left behind
  a_busy_state: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_busy_res == (st_r.phase != PH_IDLE))
    else $error("busy_res disagrees with sequencer state");

  // input side stalls only when both registers are full and the output is held
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> s1_vld_r && out_vld_r && !out_ready)
    else $error("in_ready low without a full pipeline");

  // a timeout is only ever reported on a completing item
  a_timeout_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_TIMEOUT) |-> out_finished)
    else $error("timeout status without completion");

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
`timescale 1ns / 1ps

// Item-level check of the Microwire EEPROM master.
// Every accepted input item yields exactly one result item: the pin levels
// for that tick plus the busy, read word, finished and status flags.  A
// behavioural copy of the sequencer in this file predicts each result; the
// results are then checked in order as they leave the block.

module tb;
  import mwe_pkg::*;

  localparam int FRAME_BITS = 11;              // start + opcode + address field
  localparam int FIELD_BITS = FRAME_BITS - 3;
  localparam int WORD_BITS  = 16;
  localparam int ADDR_BITS  = 7;

  // opcodes the block does not know; they must behave as a tick
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  // how data_in_pin is driven on the ticks that run a command out
  localparam int FILL_NONE   = 0;
  localparam int FILL_LOW    = 1;
  localparam int FILL_HIGH   = 2;
  localparam int FILL_RANDOM = 3;

  localparam int ITEMS_PER_PHASE = 160;

  // results that can be read straight off the pin protocol
  localparam mwe_res_t IDLE_RES   = '{1'b0, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0, ST_OK};
  // first tick of any command: reset clock high, chip select still low
  localparam mwe_res_t START_RES  = '{1'b0, 1'b1, 1'b0, 1'b1, 16'h0000, 1'b0, ST_OK};
  // command arriving on the reset-clock low phase: bounced, pins all low
  localparam mwe_res_t REJECT_RES = '{1'b0, 1'b0, 1'b0, 1'b1, 16'h0000, 1'b0, ST_REJECT};

  typedef struct {
    logic [2:0]  op;
    logic [6:0]  addr;
    logic [15:0] wdata;
    logic        din;
    int          fill;     // how to run the sequence out after this item
    bit          known;    // result typed in below rather than predicted
    mwe_res_t    res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [2:0]        in_opcode = OP_TICK;
  logic [6:0]        in_word_address = '0;
  logic [WORD_W-1:0] in_write_data = '0;
  logic              in_data_in_pin = 1'b0;

  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              out_chip_select;
  logic              out_serial_clock;
  logic              out_data_out_pin;
  logic              out_busy_res;
  logic [WORD_W-1:0] out_read_word;
  logic              out_finished;
  logic [1:0]        out_status;

  logic              cfg_wr_en = 1'b0;
  logic [WORD_W-1:0] cfg_wr_data = '0;

  // predicted sequencer state, same reset values as the block
  phase_t      seq_phase = PH_IDLE;
  logic [4:0]  seq_bits  = '0;
  logic [15:0] seq_shift = '0;
  logic [2:0]  seq_cmd   = '0;
  logic [15:0] seq_polls = '0;
  logic [15:0] seq_word  = '0;
  logic [15:0] seq_hold  = '0;
  logic [15:0] seq_limit = POLL_LIMIT_RST;

  mwe_res_t expected_pins[$];

  bit steady = 1'b0;          // both sides run flat out while set
  int errors = 0;
  int items_used = 0;         // items that were not simply ignored
  int cmds_started = 0;
  int reads_done = 0;
  int write_timeouts = 0;
  int rejects = 0;
  int results_checked = 0;

  logic [15:0] limit_plan [0:4] = '{16'd1, 16'd65535, 16'd3, 16'd0, 16'd500};

  // Directed items.  Known rows carry the result typed in; the rest, and the
  // ticks that run each command out, are checked against the prediction.
  dir_row_t directed_rows [0:13] = '{
    '{OP_TICK,      7'h00, 16'h0000, 1'b1, FILL_NONE,   1'b1, IDLE_RES},
    '{OP_SPARE_6,   7'h7F, 16'hFFFF, 1'b1, FILL_NONE,   1'b1, IDLE_RES},
    '{OP_SPARE_7,   7'h00, 16'h0000, 1'b0, FILL_NONE,   1'b1, IDLE_RES},
    '{OP_ENABLE,    7'h00, 16'h0000, 1'b0, FILL_NONE,   1'b1, START_RES},
    // read while the enable is still in its reset clock
    '{OP_READ,      7'h7F, 16'hFFFF, 1'b1, FILL_RANDOM, 1'b1, REJECT_RES},
    // write all ones, EEPROM ready on the first poll
    '{OP_WRITE,     7'h00, 16'hFFFF, 1'b0, FILL_HIGH,   1'b0, '0},
    '{OP_READ,      7'h7F, 16'h0000, 1'b1, FILL_HIGH,   1'b0, '0},
    '{OP_READ,      7'h00, 16'hFFFF, 1'b0, FILL_LOW,    1'b0, '0},
    '{OP_WRITE,     7'h7F, 16'h0000, 1'b1, FILL_HIGH,   1'b0, '0},
    // write with the EEPROM going ready at random
    '{OP_WRITE,     7'h55, 16'hA5A5, 1'b0, FILL_RANDOM, 1'b0, '0},
    // erase all finishes on its last frame bit, address ignored
    '{OP_ERASE_ALL, 7'h7F, 16'hFFFF, 1'b1, FILL_RANDOM, 1'b0, '0},
    '{OP_DISABLE,   7'h7F, 16'h0000, 1'b0, FILL_RANDOM, 1'b0, '0},
    '{OP_READ,      7'h2A, 16'h5A5A, 1'b1, FILL_RANDOM, 1'b0, '0},
    '{OP_WRITE,     7'h2A, 16'h8001, 1'b0, FILL_RANDOM, 1'b0, '0}
  };

  microwire_eeprom_master #(
    .COMMAND_BITS (FRAME_BITS),
    .DATA_BITS    (WORD_BITS),
    .ADDRESS_BITS (ADDR_BITS)
  ) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_word_address  (in_word_address),
    .in_write_data    (in_write_data),
    .in_data_in_pin   (in_data_in_pin),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_chip_select  (out_chip_select),
    .out_serial_clock (out_serial_clock),
    .out_data_out_pin (out_data_out_pin),
    .out_busy_res     (out_busy_res),
    .out_read_word    (out_read_word),
    .out_finished     (out_finished),
    .out_status       (out_status),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // One pin-phase tick of the sequencer: updates the predicted state and
  // returns the result item the block should give for this input item.
  function automatic mwe_res_t eeprom_tick(input logic [2:0] op, input logic [6:0] addr,
                                           input logic [15:0] wdata, input logic din);
    mwe_res_t r;
    logic rejected;
    logic is_cmd;
    logic [15:0] limit;
    logic [15:0] field;
    r = IDLE_RES;
    rejected = 1'b0;
    is_cmd = (op >= OP_READ) && (op <= OP_DISABLE);
    limit = (seq_limit == 16'd0) ? 16'd1 : seq_limit;

    if (seq_phase == PH_IDLE) begin
      if (is_cmd) begin
        // frame: start bit, two opcode bits, then the address field
        field = 16'd0;
        seq_shift = 16'd1 << (FRAME_BITS - 1);
        case (op)
          OP_READ: begin
            seq_shift = seq_shift | (16'd2 << FIELD_BITS);
            field = {9'd0, addr};
          end
          OP_WRITE: begin
            seq_shift = seq_shift | (16'd1 << FIELD_BITS);
            field = {9'd0, addr};
          end
          OP_ENABLE:    field = 16'd3 << (FIELD_BITS - 2);
          OP_ERASE_ALL: field = 16'd2 << (FIELD_BITS - 2);
          default:      field = 16'd0;   // write disable: opcode 00, field 00
        endcase
        seq_shift = seq_shift | (field & ((16'd1 << FIELD_BITS) - 16'd1));
        seq_cmd   = op;
        seq_hold  = wdata;
        seq_bits  = 5'(FRAME_BITS - 1);
        seq_polls = '0;
        seq_phase = PH_RST_HI;
      end
    end else if (is_cmd) begin
      rejected = 1'b1;
    end

    case (seq_phase)
      PH_IDLE: ;
      PH_RST_HI: begin
        r.sclk = 1'b1;
        seq_phase = PH_RST_LO;
      end
      PH_RST_LO: seq_phase = PH_CMD_LO;
      PH_CMD_LO: begin
        r.cs = 1'b1;
        r.dout = seq_shift[seq_bits[3:0]];
        seq_phase = PH_CMD_HI;
      end
      PH_CMD_HI: begin
        r.cs = 1'b1;
        r.sclk = 1'b1;
        r.dout = seq_shift[seq_bits[3:0]];
        if (seq_bits != 0) begin
          seq_bits--;
          seq_phase = PH_CMD_LO;
        end else if (seq_cmd == OP_READ) begin
          seq_bits = 5'(WORD_BITS - 1);
          seq_shift = '0;
          seq_phase = PH_RD_LO;
        end else if (seq_cmd == OP_WRITE) begin
          seq_bits = 5'(WORD_BITS - 1);
          seq_shift = seq_hold;
          seq_phase = PH_WR_LO;
        end else begin
          r.done = 1'b1;
          seq_phase = PH_IDLE;
        end
      end
      PH_RD_LO: begin
        r.cs = 1'b1;
        seq_phase = PH_RD_HI;
      end
      PH_RD_HI: begin
        r.cs = 1'b1;
        r.sclk = 1'b1;
        seq_shift = {seq_shift[14:0], din};
        if (seq_bits != 0) begin
          seq_bits--;
          seq_phase = PH_RD_LO;
        end else begin
          seq_word = seq_shift;
          r.done = 1'b1;
          seq_phase = PH_IDLE;
        end
      end
      PH_WR_LO: begin
        r.cs = 1'b1;
        r.dout = seq_shift[seq_bits[3:0]];
        seq_phase = PH_WR_HI;
      end
      PH_WR_HI: begin
        r.cs = 1'b1;
        r.sclk = 1'b1;
        r.dout = seq_shift[seq_bits[3:0]];
        if (seq_bits != 0) begin
          seq_bits--;
          seq_phase = PH_WR_LO;
        end else begin
          seq_phase = PH_WR_DESEL;
        end
      end
      PH_WR_DESEL: begin
        // chip select dropped for one tick to kick off programming
        seq_polls = '0;
        seq_phase = PH_POLL;
      end
      PH_POLL: begin
        r.cs = 1'b1;
        if (din) begin
          r.done = 1'b1;
          seq_phase = PH_IDLE;
        end else begin
          seq_polls = seq_polls + 16'd1;
          if (seq_polls >= limit || seq_polls == 16'd0) begin
            r.done = 1'b1;
            r.status = ST_TIMEOUT;
            seq_phase = PH_IDLE;
          end
        end
      end
      default: seq_phase = PH_IDLE;
    endcase

    // a completing item reports its own status even if a command bounced
    if (rejected && !r.done) r.status = ST_REJECT;
    r.busy = (seq_phase != PH_IDLE);
    r.read_word = seq_word;
    return r;
  endfunction

  // Present one item, hold it until accepted, then log its expected result.
  task automatic send_item(input logic [2:0] op, input logic [6:0] addr,
                           input logic [15:0] wdata, input logic din,
                           input bit typed = 1'b0, input mwe_res_t typed_res = '0);
    mwe_res_t r;
    while (!steady && $urandom_range(0, 99) < 29) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_opcode       <= op;
    in_word_address <= addr;
    in_write_data   <= wdata;
    in_data_in_pin  <= din;
    do @(posedge clk); while (!in_ready);

    if (seq_phase != PH_IDLE || (op >= OP_READ && op <= OP_DISABLE)) items_used++;
    if (seq_phase == PH_IDLE && op >= OP_READ && op <= OP_DISABLE) cmds_started++;
    r = eeprom_tick(op, addr, wdata, din);
    if (r.done && r.status == ST_OK && seq_cmd == OP_READ) reads_done++;
    if (r.done && r.status == ST_TIMEOUT) write_timeouts++;
    if (r.status == ST_REJECT) rejects++;
    expected_pins.push_back(typed ? typed_res : r);
  endtask

  // Tick until the predicted sequencer is idle again.  Under FILL_RANDOM the
  // EEPROM answers ready polls with ready_pct percent odds; noise_pct of the
  // ticks are swapped for a random opcode, which may bounce off the busy block.
  task automatic run_to_idle(input int fill, input int ready_pct, input int noise_pct);
    logic [2:0] op;
    logic din;
    while (seq_phase != PH_IDLE) begin
      op = ($urandom_range(0, 99) < noise_pct) ? 3'($urandom_range(0, 7)) : OP_TICK;
      case (fill)
        FILL_LOW:  din = 1'b0;
        FILL_HIGH: din = 1'b1;
        default:   din = (seq_phase == PH_POLL) ? ($urandom_range(0, 99) < ready_pct)
                                                : 1'($urandom);
      endcase
      send_item(op, 7'($urandom), 16'($urandom), din);
    end
  endtask

  // Register writes only once every result is home; every item has exactly
  // one result, so an empty queue means idle.
  task automatic set_poll_limit(input logic [15:0] value);
    in_valid <= 1'b0;
    while (expected_pins.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    seq_limit = value;
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t ns: %s expected %h, got %h", $time, name, want, got);
    end
  endtask

  // Result side: random back-pressure unless steady, in-order compare against predictions.
  always @(posedge clk) begin : result_check
    mwe_res_t want;
    out_ready <= steady || ($urandom_range(0, 99) >= 29);
    if (rst_n && out_valid && out_ready) begin
      if (expected_pins.size() == 0) begin
        errors++;
        $display("%0t ns: result with nothing expected, got cs %b sclk %b do %b status %h",
                 $time, out_chip_select, out_serial_clock, out_data_out_pin, out_status);
      end else begin
        want = expected_pins.pop_front();
        results_checked++;
        check_field("chip_select",  16'(want.cs),     16'(out_chip_select));
        check_field("serial_clock", 16'(want.sclk),   16'(out_serial_clock));
        check_field("data_out_pin", 16'(want.dout),   16'(out_data_out_pin));
        check_field("busy_res",     16'(want.busy),   16'(out_busy_res));
        check_field("read_word",    want.read_word,   out_read_word);
        check_field("finished",     16'(want.done),   16'(out_finished));
        check_field("status",       16'(want.status), 16'(out_status));
      end
    end
  end

  initial begin : stimulus
    int phase_base;
    int ready_pct;
    logic [15:0] lim;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed items at the reset poll limit
    for (int i = 0; i < 14; i++) begin
      send_item(directed_rows[i].op, directed_rows[i].addr, directed_rows[i].wdata,
                directed_rows[i].din, directed_rows[i].known, directed_rows[i].res);
      if (directed_rows[i].fill != FILL_NONE)
        run_to_idle(directed_rows[i].fill, 50, 0);
    end

    // random phases, one poll limit each, the extremes among them
    limit_plan[3] = 16'($urandom_range(2, 60));
    for (int p = 0; p < 5; p++) begin
      lim = limit_plan[p];
      set_poll_limit(lim);
      steady <= (p == 3);
      phase_base = items_used;
      while (items_used - phase_base < ITEMS_PER_PHASE) begin
        if ($urandom_range(0, 9) == 0) begin
          // burst of anything at all, then let it run out
          repeat ($urandom_range(1, 6))
            send_item(3'($urandom_range(0, 7)), 7'($urandom), 16'($urandom), 1'($urandom));
          run_to_idle(FILL_RANDOM, 50, 0);
        end else begin
          case ($urandom_range(0, 3))
            0:       ready_pct = (lim <= 16'd60) ? 0 : 5;
            1:       ready_pct = 5;
            2:       ready_pct = 30;
            default: ready_pct = 100;
          endcase
          send_item(3'($urandom_range(OP_READ, OP_DISABLE)), 7'($urandom),
                    16'($urandom), 1'($urandom));
          run_to_idle(FILL_RANDOM, ready_pct, 8);
        end
      end
      steady <= 1'b0;
    end

    in_valid <= 1'b0;
    while (expected_pins.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Ran %0d items through %0d commands: %0d reads, %0d write timeouts, %0d bounced.",
             items_used, cmds_started, reads_done, write_timeouts, rejects);
    $display("Poll limits 6000, 1, 65535, 3, %0d and 500; %0d results compared.",
             limit_plan[3], results_checked);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // watchdog: far beyond the expected run length
  initial begin : watchdog
    #20_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

>>> files.f
rtl/core/mwe_pkg.sv
rtl/core/mwe_step.sv
rtl/core/microwire_eeprom_master.sv
tb/sv/tb.sv
